[hw/rtl/emf_pkg.sv]
`default_nettype none

package emf_pkg;

  // window lengths and sample format
  localparam int unsigned OPEN_LEN  = 51;
  localparam int unsigned CLOSE_LEN = 77;
  localparam int unsigned SE_LEN    = 5;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned NOISE_W   = 18;
  localparam int unsigned OUT_W     = 18;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // raw delay matches the summed center lags of the four baseline windows
  localparam int unsigned OPEN_LAG  = OPEN_LEN - 1 - (OPEN_LEN - 1) / 2;
  localparam int unsigned CLOSE_LAG = CLOSE_LEN - 1 - (CLOSE_LEN - 1) / 2;
  localparam int unsigned RAW_DEPTH = 2 * OPEN_LAG + 2 * CLOSE_LAG + 1;

  // sample counts at which each stage holds a full window
  localparam int unsigned FILL_OE  = OPEN_LEN;
  localparam int unsigned FILL_OD  = FILL_OE + OPEN_LEN - 1;
  localparam int unsigned FILL_CD  = FILL_OD + CLOSE_LEN - 1;
  localparam int unsigned FILL_CE  = FILL_CD + CLOSE_LEN - 1;
  localparam int unsigned FILL_SE  = FILL_CE + SE_LEN - 1;
  localparam int unsigned FILL_ALL = FILL_SE + SE_LEN - 1;
  localparam int unsigned FILL_W   = $clog2(FILL_ALL + 1);

  // shared window memory layout
  localparam int unsigned BASE_OE   = 0;
  localparam int unsigned BASE_OD   = BASE_OE + OPEN_LEN;
  localparam int unsigned BASE_CD   = BASE_OD + OPEN_LEN;
  localparam int unsigned BASE_CE   = BASE_CD + CLOSE_LEN;
  localparam int unsigned BASE_RAW  = BASE_CE + CLOSE_LEN;
  localparam int unsigned MEM_DEPTH = BASE_RAW + RAW_DEPTH;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
  localparam int unsigned MAX_LEN   = (OPEN_LEN > CLOSE_LEN) ? OPEN_LEN : CLOSE_LEN;
  localparam int unsigned LEN_W     = $clog2(MAX_LEN + 1);
  localparam int unsigned RAW_AW    = $clog2(RAW_DEPTH);

  // baseline stage index
  typedef logic [1:0] stage_t;
  localparam stage_t ST_OE = 2'd0;
  localparam stage_t ST_OD = 2'd1;
  localparam stage_t ST_CD = 2'd2;
  localparam stage_t ST_CE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SE_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SE_NEAR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SE_FAR    = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic   load;
    logic   raw_wr;
    logic   raw_rd;
    logic   raw_cap;
    logic   win_wr;
    logic   scan;
    stage_t stage;
    logic   noise_d;
    logic   noise_ab;
    logic   result;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic stage_full;
    logic scan_last;
    logic full_se;
    logic full_all;
    logic out_free;
  } sts_t;

  function automatic logic [MEM_AW-1:0] win_base(stage_t st);
    logic [MEM_AW-1:0] b;
    unique case (st)
      ST_OE: b = MEM_AW'(BASE_OE);
      ST_OD: b = MEM_AW'(BASE_OD);
      ST_CD: b = MEM_AW'(BASE_CD);
      ST_CE: b = MEM_AW'(BASE_CE);
    endcase
    return b;
  endfunction

  function automatic logic [LEN_W-1:0] win_len(stage_t st);
    logic [LEN_W-1:0] l;
    unique case (st)
      ST_OE, ST_OD: l = LEN_W'(OPEN_LEN);
      ST_CD, ST_CE: l = LEN_W'(CLOSE_LEN);
    endcase
    return l;
  endfunction

  function automatic logic [FILL_W-1:0] win_fill(stage_t st);
    logic [FILL_W-1:0] f;
    unique case (st)
      ST_OE: f = FILL_W'(FILL_OE);
      ST_OD: f = FILL_W'(FILL_OD);
      ST_CD: f = FILL_W'(FILL_CD);
      ST_CE: f = FILL_W'(FILL_CE);
    endcase
    return f;
  endfunction

  // dilation stages take the maximum, erosion stages the minimum
  function automatic logic win_is_max(stage_t st);
    logic m;
    unique case (st)
      ST_OD, ST_CD: m = 1'b1;
      ST_OE, ST_CE: m = 1'b0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ecg_morphological_filter_top.sv]
`default_nettype none

// ECG morphological filter. Each sample is baseline-corrected (flat opening over 51
// samples, then flat closing over 77, subtracted from the center-aligned raw sample)
// and noise-suppressed (mean of the five-tap weighted close and open paths, halved
// toward zero). One sample is processed at a time: the next is accepted only once the
// last is done, paced by the serial min/max scan of the four baseline windows through
// the single-port window memory (one entry per cycle) and by a stalled output. No
// result appears for the first 260 samples after reset; after that every sample gives
// one result. No clearing pass is needed after reset. The user must write se_center,
// se_near and se_far (indexes 0, 1, 2) only while idle; the block does not enforce it.
module ecg_morphological_filter_top
  import emf_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [CFG_W-1:0]            cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic signed [SAMPLE_W-1:0]  sample_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed [OUT_W-1:0]          filtered_value_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  emf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // windows, noise stage and output register
  emf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .sample_i         (sample_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .filtered_value_o (filtered_value_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

`default_nettype wire

[hw/rtl/emf_ctrl.sv]
`default_nettype none

module emf_ctrl
  import emf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_RAW_WR   = 10'b00_0000_0010,
    S_RAW_RD   = 10'b00_0000_0100,
    S_RAW_CAP  = 10'b00_0000_1000,
    S_WIN_WR   = 10'b00_0001_0000,
    S_SCAN     = 10'b00_0010_0000,
    S_NOISE_D  = 10'b00_0100_0000,
    S_NOISE_AB = 10'b00_1000_0000,
    S_RESULT   = 10'b01_0000_0000,
    S_SPARE    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  stage_t stage_q, stage_d;

  // sequencing of one sample through the stages
  always_comb begin
    state_d   = state_q;
    stage_d   = stage_q;
    cmd_o     = '0;
    cmd_o.stage = stage_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RAW_WR;
        end
      end
      S_RAW_WR: begin
        cmd_o.raw_wr = 1'b1;
        state_d      = S_RAW_RD;
      end
      S_RAW_RD: begin
        cmd_o.raw_rd = 1'b1;
        state_d      = S_RAW_CAP;
      end
      S_RAW_CAP: begin
        cmd_o.raw_cap = 1'b1;
        stage_d       = ST_OE;
        state_d       = S_WIN_WR;
      end
      S_WIN_WR: begin
        cmd_o.win_wr = 1'b1;
        state_d      = sts_i.stage_full ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          if (stage_q == ST_CE) begin
            state_d = S_NOISE_D;
          end else begin
            stage_d = stage_t'(stage_q + 2'd1);
            state_d = S_WIN_WR;
          end
        end
      end
      S_NOISE_D: begin
        cmd_o.noise_d = 1'b1;
        state_d       = sts_i.full_se ? S_NOISE_AB : S_IDLE;
      end
      S_NOISE_AB: begin
        cmd_o.noise_ab = 1'b1;
        state_d        = sts_i.full_all ? S_RESULT : S_IDLE;
      end
      S_RESULT: begin
        cmd_o.result = 1'b1;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SPARE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stage_q <= ST_OE;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/emf_dp.sv]
`default_nettype none

module emf_dp
  import emf_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [CFG_W-1:0]            cfg_wdata_i,
  input  wire logic signed [SAMPLE_W-1:0]  sample_i,
  input  wire logic                        out_stall_i,
  output logic                             out_valid_o,
  output logic signed [OUT_W-1:0]          filtered_value_o,
  input  wire cmd_t                        cmd_i,
  output sts_t                             sts_o
);

  logic [CFG_W-1:0] se_center_q, se_near_q, se_far_q;
  logic [FILL_W-1:0] fill_q;
  logic [RAW_AW-1:0] wp_q, wp_next;
  logic [LEN_W-1:0]  ptr_q [4];
  logic [LEN_W-1:0]  cnt_q;
  logic [LEN_W-1:0]  cur_len;
  logic signed [SAMPLE_W-1:0] x_q, v_q, delayed_q, rdata_q, wdata;
  logic [SAMPLE_W-1:0] mem_q [MEM_DEPTH];
  logic [MEM_AW-1:0] addr;
  logic mem_we, mem_re;
  logic signed [NOISE_W-1:0] n0_q [SE_LEN];
  logic signed [NOISE_W-1:0] n1_q [SE_LEN];
  logic signed [NOISE_W-1:0] n2_q [SE_LEN];
  logic [CFG_W-1:0] w_tap [SE_LEN];
  logic signed [NOISE_W-1:0] a_tap [SE_LEN];
  logic signed [NOISE_W-1:0] b_tap [SE_LEN];
  logic signed [NOISE_W-1:0] a_w, b_w, d_w, mn_w, mx_w;
  logic signed [NOISE_W:0] sum_w, rnd_w, half_w;
  logic out_valid_q;
  logic signed [OUT_W-1:0] out_q;
  logic out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      se_center_q <= 4'd5;
      se_near_q   <= 4'd1;
      se_far_q    <= 4'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SE_CENTER: se_center_q <= cfg_wdata_i;
        CFG_SE_NEAR:   se_near_q   <= cfg_wdata_i;
        CFG_SE_FAR:    se_far_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cur_len = win_len(cmd_i.stage);
  assign wp_next = (wp_q == RAW_AW'(RAW_DEPTH - 1)) ? '0 : RAW_AW'(wp_q + 1'b1);

  // window memory address and write data
  always_comb begin
    addr   = '0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    wdata  = x_q;
    if (cmd_i.raw_wr) begin
      mem_we = 1'b1;
      addr   = MEM_AW'(BASE_RAW) + MEM_AW'(wp_q);
    end else if (cmd_i.raw_rd) begin
      mem_re = 1'b1;
      addr   = MEM_AW'(BASE_RAW) + MEM_AW'(wp_next);
    end else if (cmd_i.win_wr) begin
      mem_we = 1'b1;
      addr   = win_base(cmd_i.stage) + MEM_AW'(ptr_q[cmd_i.stage]);
      wdata  = (cmd_i.stage == ST_OE) ? x_q : v_q;
    end else if (cmd_i.scan) begin
      mem_re = (cnt_q != cur_len);
      addr   = win_base(cmd_i.stage) + MEM_AW'(cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= $signed(mem_q[addr]);
    end
  end

  // fill count, write positions and scan counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      wp_q   <= '0;
      cnt_q  <= '0;
      for (int i = 0; i < 4; i++) begin
        ptr_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load && (fill_q != FILL_W'(FILL_ALL))) begin
        fill_q <= FILL_W'(fill_q + 1'b1);
      end
      if (cmd_i.raw_rd) begin
        wp_q <= wp_next;
      end
      if (cmd_i.win_wr) begin
        cnt_q <= '0;
        ptr_q[cmd_i.stage] <= (ptr_q[cmd_i.stage] == LEN_W'(cur_len - 1'b1)) ? '0
                              : LEN_W'(ptr_q[cmd_i.stage] + 1'b1);
      end else if (cmd_i.scan) begin
        cnt_q <= LEN_W'(cnt_q + 1'b1);
      end
    end
  end

  // sample latch, delayed sample and serial min/max accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= sample_i;
    end
    if (cmd_i.raw_cap) begin
      delayed_q <= rdata_q;
    end
    if (cmd_i.scan && (cnt_q != '0)) begin
      if (cnt_q == LEN_W'(1)) begin
        v_q <= rdata_q;
      end else if (win_is_max(cmd_i.stage)) begin
        v_q <= (rdata_q > v_q) ? rdata_q : v_q;
      end else begin
        v_q <= (rdata_q < v_q) ? rdata_q : v_q;
      end
    end
  end

  // baseline-corrected difference
  assign d_w = $signed({{(NOISE_W-SAMPLE_W){delayed_q[SAMPLE_W-1]}}, delayed_q})
             - $signed({{(NOISE_W-SAMPLE_W){v_q[SAMPLE_W-1]}}, v_q});

  // weighted dilation and erosion over the five taps
  always_comb begin
    for (int k = 0; k < SE_LEN; k++) begin
      if (k == SE_LEN / 2) begin
        w_tap[k] = se_center_q;
      end else if ((k == SE_LEN / 2 - 1) || (k == SE_LEN / 2 + 1)) begin
        w_tap[k] = se_near_q;
      end else begin
        w_tap[k] = se_far_q;
      end
      a_tap[k] = n0_q[k] + $signed({{(NOISE_W-CFG_W){1'b0}}, w_tap[k]});
      b_tap[k] = n0_q[k] - $signed({{(NOISE_W-CFG_W){1'b0}}, w_tap[k]});
    end
    a_w = a_tap[0];
    b_w = b_tap[0];
    for (int k = 1; k < SE_LEN; k++) begin
      if (a_tap[k] > a_w) a_w = a_tap[k];
      if (b_tap[k] < b_w) b_w = b_tap[k];
    end
  end

  // flat erosion and dilation of the two paths, average toward zero
  always_comb begin
    mn_w = n1_q[0];
    mx_w = n2_q[0];
    for (int k = 1; k < SE_LEN; k++) begin
      if (n1_q[k] < mn_w) mn_w = n1_q[k];
      if (n2_q[k] > mx_w) mx_w = n2_q[k];
    end
    sum_w  = $signed({mn_w[NOISE_W-1], mn_w}) + $signed({mx_w[NOISE_W-1], mx_w});
    rnd_w  = sum_w + $signed({{NOISE_W{1'b0}}, sum_w[NOISE_W]});
    half_w = rnd_w >>> 1;
  end

  // noise windows
  always_ff @(posedge clk_i) begin
    if (cmd_i.noise_d) begin
      for (int k = 0; k < SE_LEN - 1; k++) begin
        n0_q[k] <= n0_q[k+1];
      end
      n0_q[SE_LEN-1] <= d_w;
    end
    if (cmd_i.noise_ab) begin
      for (int k = 0; k < SE_LEN - 1; k++) begin
        n1_q[k] <= n1_q[k+1];
        n2_q[k] <= n2_q[k+1];
      end
      n1_q[SE_LEN-1] <= a_w;
      n2_q[SE_LEN-1] <= b_w;
    end
  end

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result && out_free) begin
      out_q <= half_w[OUT_W-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_q;

  // status back to the controller
  always_comb begin
    sts_o.stage_full = (fill_q >= win_fill(cmd_i.stage));
    sts_o.scan_last  = (cnt_q == cur_len);
    sts_o.full_se    = (fill_q >= FILL_W'(FILL_SE));
    sts_o.full_all   = (fill_q >= FILL_W'(FILL_ALL));
    sts_o.out_free   = out_free;
  end

endmodule

`default_nettype wire

[hw/rtl/emf_checker.sv]
`default_nettype none

module emf_checker
  import emf_pkg::*;
(
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic signed [OUT_W-1:0]     filtered_value_o
);

  // a transfer in is followed by a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a transfer");

  // a new result is only produced while a sample is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

  // no result in the cycle right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && !in_stall_o))
    else $error("result too soon after input transfer");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(filtered_value_o)))
    else $error("stalled result changed");

endmodule

bind ecg_morphological_filter_top emf_checker u_emf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .filtered_value_o (filtered_value_o)
);

`default_nettype wire
